/* rtl/depq_pkg.sv */
`timescale 1ns / 1ps
package depq_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int HELD_W   = 7;
    localparam int OUT_W    = 72;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* rtl/depq_ram.sv */
`timescale 1ns / 1ps
module depq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

/* rtl/double_ended_priority_queue_top.sv */
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                               | tuser
// s       | in  | value[31:0]                                      | op[1:0]
// m       | out | is_empty, held_count[6:0], largest, smallest     | status[1:0]
//
// Insert, clear and a delete on an empty queue go from S_IDLE straight to S_DONE;
// any other delete passes through S_MOVE_RD, S_MOVE_WR and S_SCAN, where the single
// read port scans every held entry for the new max/min.
// One request is in work at a time; s tready drops until its result is taken.
// i_rst_n (synchronous, active low) empties the queue; store contents are
// left as they are. A stalled m channel holds its transaction in place.
module double_ended_priority_queue_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [depq_pkg::VAL_W-1:0] i_s_tdata,   // value
    input  logic [1:0]                i_s_tuser,    // op
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [depq_pkg::OUT_W-1:0] o_m_tdata,   // is_empty, held_count, largest, smallest
    output logic [1:0]                o_m_tuser     // status
);
    import depq_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [VAL_W-1:0]  r_max, r_min;
    logic [ADDR_W-1:0] r_max_addr, r_min_addr, r_del_addr;
    t_status           r_status;
    logic [CNT_W-1:0]  r_scan_idx;
    logic              r_scan_rv, r_scan_first;
    logic [ADDR_W-1:0] r_scan_addr;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [1:0]        r_out_user;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0]  wr_data, rd_data;
    logic              s_fire;
    t_op               in_op;
    logic [CNT_W-1:0]  last_idx;
    logic              scan_done;

    assign in_op     = t_op'(i_s_tuser);
    assign o_s_tready = (r_state == S_IDLE) && !r_out_valid;
    assign s_fire    = i_s_tvalid && o_s_tready;
    assign last_idx  = r_count - CNT_W'(1);
    assign scan_done = (r_scan_idx == r_count) && !r_scan_rv;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    depq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if ((in_op == OP_DEL_MAX || in_op == OP_DEL_MIN) && r_count != '0) begin
                        n_state = S_MOVE_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[ADDR_W-1:0];
        wr_data = i_s_tdata;
        rd_addr = r_scan_idx[ADDR_W-1:0];
        unique case (r_state) inside
            S_IDLE: begin
                wr_en = s_fire && (in_op == OP_INSERT) && (r_count < CNT_W'(CAPACITY));
            end
            S_MOVE_RD: rd_addr = last_idx[ADDR_W-1:0];
            S_MOVE_WR: begin
                // last entry fills the hole left by the deleted one
                wr_en   = 1'b1;
                wr_addr = r_del_addr;
                wr_data = rd_data;
            end
            S_SCAN, S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_scan_rv   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_status <= ST_DONE;
                        case (in_op) inside
                            OP_INSERT: begin
                                if (r_count >= CNT_W'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                    if (r_count == '0 || $signed(i_s_tdata) > $signed(r_max)) begin
                                        r_max      <= i_s_tdata;
                                        r_max_addr <= r_count[ADDR_W-1:0];
                                    end
                                    if (r_count == '0 || $signed(i_s_tdata) < $signed(r_min)) begin
                                        r_min      <= i_s_tdata;
                                        r_min_addr <= r_count[ADDR_W-1:0];
                                    end
                                end
                            end
                            OP_DEL_MAX, OP_DEL_MIN: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_del_addr <= (in_op == OP_DEL_MAX) ? r_max_addr : r_min_addr;
                                end
                            end
                            default: r_count <= '0;
                        endcase
                    end
                end
                S_MOVE_RD: ;
                S_MOVE_WR: begin
                    r_count      <= last_idx;
                    r_scan_idx   <= '0;
                    r_scan_rv    <= 1'b0;
                    r_scan_first <= 1'b1;
                end
                S_SCAN: begin
                    // issue one read per cycle, fold returning data in the next cycle
                    r_scan_rv   <= (r_scan_idx < r_count);
                    r_scan_addr <= r_scan_idx[ADDR_W-1:0];
                    if (r_scan_idx < r_count) r_scan_idx <= r_scan_idx + CNT_W'(1);
                    if (r_scan_rv) begin
                        r_scan_first <= 1'b0;
                        if (r_scan_first || $signed(rd_data) > $signed(r_max)) begin
                            r_max      <= rd_data;
                            r_max_addr <= r_scan_addr;
                        end
                        if (r_scan_first || $signed(rd_data) < $signed(r_min)) begin
                            r_min      <= rd_data;
                            r_min_addr <= r_scan_addr;
                        end
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out_user <= r_status;
            if (r_count == '0) begin
                r_out_data <= {{(2*VAL_W){1'b0}}, HELD_W'(0), 1'b1};
            end else begin
                r_out_data <= {r_min, r_max, HELD_W'(r_count), 1'b0};
            end
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
    import depq_pkg::*;

    typedef struct packed {
        t_status            status;
        logic               is_empty;
        logic [HELD_W-1:0]  held;
        logic [VAL_W-1:0]   largest;
        logic [VAL_W-1:0]   smallest;
    } t_reply;

    typedef struct {
        t_op            op;
        logic [31:0]    value;
        bit             typed;
        t_reply         reply;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [VAL_W-1:0]   i_s_tdata;      // value
    logic [1:0]         i_s_tuser;      // op
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;      // is_empty, held_count[6:0], largest, smallest
    logic [1:0]         o_m_tuser;      // status

    double_ended_priority_queue_top dut (.*);

    // model of the queue contents, ascending signed order
    int             held_vals[$];
    t_reply         pending_replies[$];
    int             errors;
    int             send_gap;
    int             take_gap;
    int             n_full;
    int             n_empty;
    int             n_max_count;
    int             n_taken;

    localparam int DIRECTED_N = 20;
    t_row steps[DIRECTED_N];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

    // apply one request to the model and return the reply it gives
    function automatic t_reply queue_step(t_op op, logic [31:0] value);
        t_reply r;
        int pos;
        r.status = ST_DONE;
        case (op)
            OP_INSERT: begin
                if (held_vals.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = held_vals.size();
                    while (pos > 0 && held_vals[pos-1] > $signed(value)) pos--;
                    held_vals.insert(pos, $signed(value));
                end
            end
            OP_DEL_MAX: begin
                if (held_vals.size() == 0) r.status = ST_EMPTY;
                else void'(held_vals.pop_back());
            end
            OP_DEL_MIN: begin
                if (held_vals.size() == 0) r.status = ST_EMPTY;
                else void'(held_vals.pop_front());
            end
            default: held_vals.delete();
        endcase
        r.is_empty = (held_vals.size() == 0);
        r.held     = HELD_W'(held_vals.size());
        r.largest  = r.is_empty ? '0 : held_vals[$];
        r.smallest = r.is_empty ? '0 : held_vals[0];
        return r;
    endfunction

    // one request: random idle cycles, then hold until the transaction goes through
    task automatic push_request(t_op op, logic [31:0] value, bit typed, t_reply typed_reply);
        t_reply r;
        while ($urandom_range(0, 99) < send_gap) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = queue_step(op, value);
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_EMPTY) n_empty++;
        if (r.held == CAPACITY) n_max_count++;
        pending_replies.push_back(typed ? typed_reply : r);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // pick an op; bias swings the queue between filling and draining
    function automatic t_op pick_op(int bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return OP_CLEAR;
        if (r < bias) return OP_INSERT;
        return (r[0]) ? OP_DEL_MAX : OP_DEL_MIN;
    endfunction

    // result side: compare each transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status   = t_status'(o_m_tuser);
                got.is_empty = o_m_tdata[0];
                got.held     = o_m_tdata[7:1];
                got.largest  = o_m_tdata[39:8];
                got.smallest = o_m_tdata[71:40];
                if (pending_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, got);
                end else begin
                    want = pending_replies.pop_front();
                    n_taken++;
                    if (got.status !== want.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    if (got.is_empty !== want.is_empty)
                        $display("%0t: is_empty exp %0d got %0d", $time,
                                 want.is_empty, got.is_empty);
                    if (got.held !== want.held)
                        $display("%0t: held_count exp %0d got %0d", $time, want.held, got.held);
                    if (got.largest !== want.largest)
                        $display("%0t: largest exp %h got %h", $time,
                                 want.largest, got.largest);
                    if (got.smallest !== want.smallest)
                        $display("%0t: smallest exp %h got %h", $time,
                                 want.smallest, got.smallest);
                    if (got !== want) errors++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= take_gap);
    end

    initial begin
        // directed rows: typed expectations where obvious, rest from the model
        steps[0]  = '{OP_DEL_MAX, 32'h0,         1, '{ST_EMPTY, 1, 0, 0, 0}};
        steps[1]  = '{OP_DEL_MIN, 32'hffff_ffff, 1, '{ST_EMPTY, 1, 0, 0, 0}};
        steps[2]  = '{OP_CLEAR,   32'h0,         1, '{ST_DONE,  1, 0, 0, 0}};
        steps[3]  = '{OP_INSERT,  32'h7fff_ffff, 1,
                      '{ST_DONE, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff}};
        steps[4]  = '{OP_INSERT,  32'h8000_0000, 1,
                      '{ST_DONE, 0, 2, 32'h7fff_ffff, 32'h8000_0000}};
        steps[5]  = '{OP_INSERT,  32'h0,         0, '0};
        steps[6]  = '{OP_INSERT,  32'h0,         0, '0};
        steps[7]  = '{OP_INSERT,  32'hffff_ffff, 0, '0};
        steps[8]  = '{OP_DEL_MAX, 32'h0,         0, '0};
        steps[9]  = '{OP_DEL_MIN, 32'h0,         0, '0};
        steps[10] = '{OP_DEL_MAX, 32'h0,         0, '0};
        steps[11] = '{OP_DEL_MIN, 32'h0,         0, '0};
        steps[12] = '{OP_DEL_MIN, 32'h0,         1, '{ST_DONE,  1, 0, 0, 0}};
        steps[13] = '{OP_DEL_MAX, 32'h0,         1, '{ST_EMPTY, 1, 0, 0, 0}};
        steps[14] = '{OP_INSERT,  32'h5,         0, '0};
        steps[15] = '{OP_INSERT,  32'h5,         0, '0};
        steps[16] = '{OP_CLEAR,   32'h0,         1, '{ST_DONE,  1, 0, 0, 0}};
        steps[17] = '{OP_INSERT,  32'h5555_5555, 0, '0};
        steps[18] = '{OP_INSERT,  32'haaaa_aaaa, 0, '0};
        steps[19] = '{OP_DEL_MAX, 32'h0,         0, '0};

        errors = 0; n_full = 0; n_empty = 0; n_max_count = 0; n_taken = 0;
        send_gap = 36; take_gap = 77;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_INSERT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[k])
            push_request(steps[k].op, steps[k].value, steps[k].typed, steps[k].reply);

        for (int n = 0; n < 1530; n++) begin
            if (n == 510) begin
                send_gap = 77; take_gap = 36;
            end
            if (n == 1020) begin
                send_gap = 0; take_gap = 0;
            end
            // hold off until the queue has drained every reply
            if (n == 700) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_replies.size() != 0) @(posedge i_clk);
            end
            // sweep the fill level: heavy inserts, then heavy deletes
            push_request(pick_op(((n / 120) % 2 == 0) ? 80 : 25), pick_value(), 0, '0);
        end
        i_s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("ran %0d requests: %0d inserts dropped when full, %0d deletes on empty,",
                 DIRECTED_N + 1530, n_full, n_empty);
        $display("%0d results at full capacity, %0d results checked", n_max_count, n_taken);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/depq_pkg.sv
rtl/depq_ram.sv
rtl/double_ended_priority_queue_top.sv
bench/tb.sv
